/* sv/sra_pkg.sv */
// Shared types, constants and lookup tables for the slab run allocator.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`default_nettype none

package sra_pkg;

  // Chunk geometry.
  localparam int unsigned RUN_BYTES      = 4096;
  localparam int unsigned RUNS_PER_CHUNK = 16;
  localparam int unsigned SMALL_LIMIT    = 2048;
  localparam int unsigned HEADER_BYTES   = 64;
  localparam int unsigned RUN_SPACE      = RUN_BYTES - HEADER_BYTES;
  localparam int unsigned FINE_LIMIT     = 96;
  localparam int unsigned MID_LIMIT      = 512;

  // Widths.
  localparam int unsigned RUN_W       = $clog2(RUNS_PER_CHUNK);
  localparam int unsigned INRUN_W     = $clog2(RUN_BYTES);
  localparam int unsigned HEAD_W      = INRUN_W + 1;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned CLS_W       = 4;
  localparam int unsigned ELEM_W      = 12;
  localparam int unsigned OFF_W       = RUN_W + INRUN_W;
  localparam int unsigned STORE_DEPTH = RUNS_PER_CHUNK * RUN_BYTES / 8;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned RUNS_W      = RUN_W + 1;

  localparam logic [HEAD_W-1:0] NULL_SLOT = HEAD_W'(RUN_BYTES);
  localparam logic [HEAD_W-1:0] HDR_SLOT  = HEAD_W'(HEADER_BYTES);

  // Opcodes.
  localparam logic [2:0] OP_CLASS = 3'd0;
  localparam logic [2:0] OP_OPEN  = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  // Status codes.
  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_CHUNK_FULL   = 3'd1;
  localparam logic [2:0] STS_RUN_INACTIVE = 3'd2;
  localparam logic [2:0] STS_RUN_FULL     = 3'd3;
  localparam logic [2:0] STS_BAD_OFFSET   = 3'd4;
  localparam logic [2:0] STS_BAD_SIZE     = 3'd5;

  localparam logic [CLS_W-1:0] LAST_CLASS = 4'd14;

  // Slot size of each class; code 15 behaves as class 0.
  localparam int unsigned ELEM_TAB [16] = '{
    0, 8, 16, 32, 48, 64, 96, 128, 192, 256, 384, 512, 768, 1280, SMALL_LIMIT, 0
  };

  // Slots that fit in one run after the header.
  localparam int unsigned TOTAL_TAB [16] = '{
    0, RUN_SPACE / 8, RUN_SPACE / 16, RUN_SPACE / 32, RUN_SPACE / 48,
    RUN_SPACE / 64, RUN_SPACE / 96, RUN_SPACE / 128, RUN_SPACE / 192,
    RUN_SPACE / 256, RUN_SPACE / 384, RUN_SPACE / 512, RUN_SPACE / 768,
    RUN_SPACE / 1280, RUN_SPACE / SMALL_LIMIT, 0
  };

  // Bytes covered by all slots of a run.
  localparam int unsigned SPAN_TAB [16] = '{
    0, (RUN_SPACE / 8) * 8, (RUN_SPACE / 16) * 16, (RUN_SPACE / 32) * 32,
    (RUN_SPACE / 48) * 48, (RUN_SPACE / 64) * 64, (RUN_SPACE / 96) * 96,
    (RUN_SPACE / 128) * 128, (RUN_SPACE / 192) * 192, (RUN_SPACE / 256) * 256,
    (RUN_SPACE / 384) * 384, (RUN_SPACE / 512) * 512, (RUN_SPACE / 768) * 768,
    (RUN_SPACE / 1280) * 1280, (RUN_SPACE / SMALL_LIMIT) * SMALL_LIMIT, 0
  };

  // Slot size split as odd factor times a power of two.
  localparam int unsigned SHIFT_TAB [16] = '{
    0, 3, 4, 5, 4, 6, 5, 7, 6, 8, 7, 9, 8, 8, 11, 0
  };
  localparam int unsigned ODD_TAB [16] = '{
    1, 1, 1, 1, 3, 1, 3, 1, 3, 1, 3, 1, 3, 5, 1, 1
  };

  // Size to class maps; of the upper fine entries only the last is selected, for a zero size.
  localparam logic [CLS_W-1:0] FINE_MAP [16] = '{
    4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0
  };
  localparam logic [CLS_W-1:0] MID_MAP [16] = '{
    4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11
  };
  localparam logic [CLS_W-1:0] COARSE_MAP [16] = '{
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13,
    4'd13, 4'd13, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14
  };

  // Decoded command passed from the front to the back.
  typedef struct packed {
    logic [2:0]       op;
    logic             bad;
    logic [CLS_W-1:0] cls;
    logic [RUN_W-1:0] run_sel;
    logic [OFF_W-1:0] off;
    logic             other;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [2:0]        status;
    logic [CLS_W-1:0]  cls;
    logic [ELEM_W-1:0] elem;
    logic [RUN_W-1:0]  run;
    logic [OFF_W-1:0]  slot;
    logic              became;
    logic              was;
    logic              rel;
    logic              cfull;
    logic              unused;
  } res_t;

  function automatic logic [ELEM_W-1:0] elem_of(input logic [CLS_W-1:0] c);
    elem_of = ELEM_W'(ELEM_TAB[c]);
  endfunction

  function automatic logic [CNT_W-1:0] total_of(input logic [CLS_W-1:0] c);
    total_of = CNT_W'(TOTAL_TAB[c]);
  endfunction

  function automatic logic [INRUN_W-1:0] span_of(input logic [CLS_W-1:0] c);
    span_of = INRUN_W'(SPAN_TAB[c]);
  endfunction

  // True when d is a whole multiple of the slot size of class c.
  function automatic logic slot_aligned(input logic [INRUN_W-1:0] d,
                                        input logic [CLS_W-1:0]   c);
    logic [INRUN_W-1:0]   mask;
    logic [INRUN_W-1:0]   q0;
    logic [2*INRUN_W-1:0] p;
    logic [INRUN_W-1:0]   q;
    logic                 ok;
    mask = INRUN_W'((1 << SHIFT_TAB[c]) - 1);
    q0   = d >> SHIFT_TAB[c];
    p    = '0;
    q    = '0;
    case (ODD_TAB[c])
      3: begin
        // Divide by three through a reciprocal, exact for 12-bit values.
        p  = (2*INRUN_W)'(q0) * (2*INRUN_W)'(2731);
        q  = INRUN_W'(p >> 13);
        ok = ((INRUN_W+2)'(q) * (INRUN_W+2)'(3)) == (INRUN_W+2)'(q0);
      end
      5: begin
        p  = (2*INRUN_W)'(q0) * (2*INRUN_W)'(3277);
        q  = INRUN_W'(p >> 14);
        ok = ((INRUN_W+3)'(q) * (INRUN_W+3)'(5)) == (INRUN_W+3)'(q0);
      end
      default: ok = 1'b1;
    endcase
    slot_aligned = ((d & mask) == '0) && ok;
  endfunction

endpackage

`default_nettype wire

/* sv/sra_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the next-slot links of the allocator.
`default_nettype none

module sra_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/sra_queue.sv */
// Two-word command queue between the front and the back of the allocator.
// Depends on sra_pkg for the command type.
`default_nettype none

module sra_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sra_pkg::cmd_t push_cmd,
  output      logic          full,
  input  wire logic          pop,
  output      logic          valid,
  output      sra_pkg::cmd_t head_cmd
);

  sra_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign head_cmd = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage for the queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/sra_front.sv */
// Front of the allocator: accepts input words and classifies them.
// Depends on sra_pkg; feeds sra_queue.
`default_nettype none

module sra_front (
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [39:0]   in_tdata,
  input  wire logic [2:0]    in_tuser,
  input  wire logic          q_full,
  output      logic          push,
  output      sra_pkg::cmd_t cmd
);

  logic [11:0]               byte_count;
  logic [11:0]               bm1;
  logic [sra_pkg::CLS_W-1:0] size_class;
  logic [sra_pkg::CLS_W-1:0] found;

  assign in_tready  = !q_full;
  assign push       = in_tvalid && !q_full;
  assign byte_count = in_tdata[11:0];
  assign size_class = in_tdata[15:12];
  assign bm1        = byte_count - 12'd1;

  // Map a byte size to its class.
  always_comb begin
    if (byte_count <= 12'(sra_pkg::FINE_LIMIT)) begin
      found = sra_pkg::FINE_MAP[bm1[6:3]];
    end else if (byte_count <= 12'(sra_pkg::MID_LIMIT)) begin
      found = sra_pkg::MID_MAP[bm1[8:5]];
    end else begin
      found = sra_pkg::COARSE_MAP[bm1[10:7]];
    end
  end

  // Build the command word; size, class and opcode errors are flagged here.
  always_comb begin
    cmd.op      = in_tuser;
    cmd.run_sel = in_tdata[19:16];
    cmd.off     = in_tdata[35:20];
    cmd.other   = in_tdata[36];
    cmd.cls     = '0;
    cmd.bad     = 1'b0;
    case (in_tuser)
      sra_pkg::OP_CLASS: begin
        cmd.bad = (byte_count == 12'd0) || (byte_count > 12'(sra_pkg::SMALL_LIMIT));
        cmd.cls = found;
      end
      sra_pkg::OP_OPEN: begin
        cmd.bad = (size_class == '0) || (size_class > sra_pkg::LAST_CLASS);
        cmd.cls = size_class;
      end
      sra_pkg::OP_ALLOC, sra_pkg::OP_FREE, sra_pkg::OP_QUERY: begin
        cmd.bad = 1'b0;
      end
      default: cmd.bad = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

/* sv/sra_back.sv */
// Back of the allocator: run tables, free-list upkeep and the result register.
// Depends on sra_pkg and sra_ram.
`default_nettype none

module sra_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire sra_pkg::cmd_t q_cmd,
  output      logic          q_pop,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      sra_pkg::res_t out_res
);

  localparam int unsigned NR = sra_pkg::RUNS_PER_CHUNK;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_FILL = 5'b00100,
    S_POP  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  sra_pkg::cmd_t cmd_r, cmd_nxt;
  sra_pkg::res_t res_r, res_nxt;
  sra_pkg::res_t out_res_r, out_res_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [NR-1:0]                  active_r, active_nxt;
  logic [sra_pkg::RUNS_W-1:0]     runs_r, runs_nxt;
  logic [sra_pkg::CLS_W-1:0]      cls_tab_r [NR];
  logic [sra_pkg::CLS_W-1:0]      cls_tab_nxt [NR];
  logic [sra_pkg::CNT_W-1:0]      used_r [NR];
  logic [sra_pkg::CNT_W-1:0]      used_nxt [NR];
  logic [sra_pkg::HEAD_W-1:0]     head_r [NR];
  logic [sra_pkg::HEAD_W-1:0]     head_nxt [NR];

  logic [sra_pkg::RUN_W-1:0]      fill_run_r, fill_run_nxt;
  logic [sra_pkg::HEAD_W-1:0]     here_r, here_nxt;
  logic [sra_pkg::CNT_W-1:0]      fill_cnt_r, fill_cnt_nxt;
  logic [sra_pkg::ELEM_W-1:0]     fill_elem_r, fill_elem_nxt;

  logic                           ram_we;
  logic [sra_pkg::STORE_AW-1:0]   ram_waddr, ram_raddr;
  logic [sra_pkg::HEAD_W-1:0]     ram_wdata, ram_rdata;

  // Values of the run that the current command names.
  logic [sra_pkg::RUN_W-1:0]      r_use;
  logic [sra_pkg::CLS_W-1:0]      cls_u;
  logic [sra_pkg::ELEM_W-1:0]     e_u;
  logic [sra_pkg::CNT_W-1:0]      n_u;
  logic [sra_pkg::CNT_W-1:0]      used_u;
  logic [sra_pkg::HEAD_W-1:0]     head_u;
  logic                           act_u;
  logic [sra_pkg::INRUN_W-1:0]    inrun;
  logic [sra_pkg::INRUN_W-1:0]    d_u;
  logic                           free_ok;
  logic [sra_pkg::RUN_W-1:0]      first_free;
  logic                           found_free;
  logic [sra_pkg::CLS_W-1:0]      open_cls;
  logic [sra_pkg::CNT_W-1:0]      open_n;

  sra_ram #(
    .WIDTH (sra_pkg::HEAD_W),
    .DEPTH (sra_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Look up the addressed run and check a freed offset.
  always_comb begin
    r_use   = (cmd_r.op == sra_pkg::OP_ALLOC) ? cmd_r.run_sel
                                              : cmd_r.off[sra_pkg::OFF_W-1:sra_pkg::INRUN_W];
    cls_u   = cls_tab_r[r_use];
    e_u     = sra_pkg::elem_of(cls_u);
    n_u     = sra_pkg::total_of(cls_u);
    used_u  = used_r[r_use];
    head_u  = head_r[r_use];
    act_u   = active_r[r_use];
    inrun   = cmd_r.off[sra_pkg::INRUN_W-1:0];
    d_u     = inrun - sra_pkg::INRUN_W'(sra_pkg::HEADER_BYTES);
    free_ok = (e_u != '0) && (inrun >= sra_pkg::INRUN_W'(sra_pkg::HEADER_BYTES))
              && sra_pkg::slot_aligned(d_u, cls_u) && (d_u < sra_pkg::span_of(cls_u))
              && (used_u != '0);
    open_cls = cmd_r.cls;
    open_n   = sra_pkg::total_of(open_cls);
  end

  // Lowest run not in use.
  always_comb begin
    first_free = '0;
    found_free = 1'b0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        first_free = sra_pkg::RUN_W'(i);
        found_free = 1'b1;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    active_nxt    = active_r;
    runs_nxt      = runs_r;
    cls_tab_nxt   = cls_tab_r;
    used_nxt      = used_r;
    head_nxt      = head_r;
    fill_run_nxt  = fill_run_r;
    here_nxt      = here_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_elem_nxt = fill_elem_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt        = '0;
        state_nxt      = S_OUT;
        if (cmd_r.bad) begin
          res_nxt.status = sra_pkg::STS_BAD_SIZE;
        end else begin
          case (cmd_r.op)
            sra_pkg::OP_CLASS: begin
              res_nxt.cls  = cmd_r.cls;
              res_nxt.elem = sra_pkg::elem_of(cmd_r.cls);
            end

            sra_pkg::OP_OPEN: begin
              if (runs_r >= sra_pkg::RUNS_W'(NR) || !found_free) begin
                res_nxt.status = sra_pkg::STS_CHUNK_FULL;
              end else begin
                active_nxt[first_free]  = 1'b1;
                runs_nxt                = runs_r + 1'b1;
                cls_tab_nxt[first_free] = open_cls;
                used_nxt[first_free]    = '0;
                head_nxt[first_free]    = (open_n != '0) ? sra_pkg::HDR_SLOT
                                                         : sra_pkg::NULL_SLOT;
                res_nxt.cls   = open_cls;
                res_nxt.elem  = sra_pkg::elem_of(open_cls);
                res_nxt.run   = first_free;
                res_nxt.cfull = (runs_r + 1'b1) == sra_pkg::RUNS_W'(NR);
                // Lay down the ascending free list one link a cycle.
                fill_run_nxt  = first_free;
                here_nxt      = sra_pkg::HDR_SLOT;
                fill_cnt_nxt  = open_n;
                fill_elem_nxt = sra_pkg::elem_of(open_cls);
                if (open_n != '0) begin
                  state_nxt = S_FILL;
                end
              end
            end

            sra_pkg::OP_ALLOC: begin
              if (r_use == '0 || !act_u) begin
                res_nxt.status = sra_pkg::STS_RUN_INACTIVE;
              end else if (used_u >= n_u || head_u >= sra_pkg::NULL_SLOT) begin
                res_nxt.status = sra_pkg::STS_RUN_FULL;
              end else begin
                ram_raddr      = {r_use, head_u[sra_pkg::INRUN_W-1:3]};
                used_nxt[r_use] = used_u + 1'b1;
                res_nxt.cls    = cls_u;
                res_nxt.elem   = e_u;
                res_nxt.run    = r_use;
                res_nxt.slot   = {r_use, head_u[sra_pkg::INRUN_W-1:0]};
                res_nxt.became = ((sra_pkg::CNT_W+1)'(used_u) + 1'b1)
                                 >= (sra_pkg::CNT_W+1)'(n_u);
                state_nxt      = S_POP;
              end
            end

            sra_pkg::OP_FREE: begin
              if (r_use == '0 || !act_u || !free_ok) begin
                res_nxt.status = sra_pkg::STS_BAD_OFFSET;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = cmd_r.off[sra_pkg::OFF_W-1:3];
                ram_wdata       = head_u;
                head_nxt[r_use] = {1'b0, inrun};
                used_nxt[r_use] = used_u - 1'b1;
                res_nxt.was     = used_u >= n_u;
                res_nxt.cls     = cls_u;
                res_nxt.elem    = e_u;
                res_nxt.run     = r_use;
                // Hand an empty run back when the pool still has another.
                if (used_u == sra_pkg::CNT_W'(1) && cmd_r.other) begin
                  active_nxt[r_use] = 1'b0;
                  res_nxt.cfull     = runs_r >= sra_pkg::RUNS_W'(NR);
                  res_nxt.rel       = 1'b1;
                  if (runs_r != '0) begin
                    runs_nxt = runs_r - 1'b1;
                  end
                  res_nxt.unused = (runs_r == sra_pkg::RUNS_W'(2));
                end
              end
            end

            sra_pkg::OP_QUERY: begin
              if (r_use == '0 || !act_u) begin
                res_nxt.status = sra_pkg::STS_BAD_OFFSET;
              end else begin
                res_nxt.cls  = cls_u;
                res_nxt.elem = e_u;
                res_nxt.run  = r_use;
              end
            end

            default: res_nxt.status = sra_pkg::STS_BAD_SIZE;
          endcase
        end
      end

      S_FILL: begin
        ram_we       = 1'b1;
        ram_waddr    = {fill_run_r, here_r[sra_pkg::INRUN_W-1:3]};
        ram_wdata    = (fill_cnt_r == sra_pkg::CNT_W'(1)) ? sra_pkg::NULL_SLOT
                       : here_r + sra_pkg::HEAD_W'(fill_elem_r);
        here_nxt     = here_r + sra_pkg::HEAD_W'(fill_elem_r);
        fill_cnt_nxt = fill_cnt_r - 1'b1;
        if (fill_cnt_r == sra_pkg::CNT_W'(1)) begin
          state_nxt = S_OUT;
        end
      end

      S_POP: begin
        // Link read from the store becomes the new head.
        head_nxt[cmd_r.run_sel] = ram_rdata;
        state_nxt               = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and run tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= NR'(1);
      runs_r      <= sra_pkg::RUNS_W'(1);
      for (int i = 0; i < NR; i++) begin
        cls_tab_r[i] <= '0;
        used_r[i]    <= '0;
        head_r[i]    <= sra_pkg::NULL_SLOT;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      runs_r      <= runs_nxt;
      cls_tab_r   <= cls_tab_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    fill_run_r  <= fill_run_nxt;
    here_r      <= here_nxt;
    fill_cnt_r  <= fill_cnt_nxt;
    fill_elem_r <= fill_elem_nxt;
  end

endmodule

`default_nettype wire

/* sv/slab_run_allocator.sv */
// Slab run allocator for one chunk: size classes, run opening, slot pop/push.
// Top level; depends on sra_pkg, sra_front, sra_queue and sra_back.
`default_nettype none

// One chunk of sixteen 4 KiB runs, each carved into slots of one of 14 size
// classes, with run 0 reserved at reset. Every input word gives exactly one
// result word, in order. Size lookups, queries, frees and all errors pass
// through the IDLE, EXEC and OUT states of the back end; an allocation adds
// a POP state for the registered read of the next-slot store, and opening a
// run adds a FILL state that writes the ascending free list into the
// next-slot store one link a cycle (up to 504 links for 8-byte slots). A
// two-word queue sits in front of the back end and the result register lets
// a new word start while the last result waits.
module slab_run_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // byte_count[11:0], size_class[15:12], run_index[19:16],
  // chunk_offset[35:20], pool_has_other[36], zero fill above
  input  wire logic [39:0] in_tdata,
  // opcode[2:0]
  input  wire logic [2:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], class_out[6:3], elem_bytes[18:7], run_out[22:19],
  // slot_offset[38:23], run_became_full[39], run_was_full[40],
  // run_released[41], chunk_was_full[42], chunk_unused[43], zero fill above
  output      logic [47:0] out_tdata
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  sra_pkg::cmd_t front_cmd;
  sra_pkg::cmd_t q_cmd;
  sra_pkg::res_t res;

  sra_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .cmd       (front_cmd)
  );

  sra_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (q_cmd)
  );

  sra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result word.
  assign out_tdata = {4'b0, res.unused, res.cfull, res.rel, res.was, res.became,
                      res.slot, res.run, res.elem, res.cls, res.status};

endmodule

`default_nettype wire

/* sv/sra_checker.sv */
// Port-level checks on the slab run allocator, bound to the top level.
// Depends only on the ports of slab_run_allocator.
`default_nettype none

module sra_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Nothing is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // An error word carries only its status.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != 3'd0) |-> (out_tdata[43:3] == 41'd0))
    else $error("error word carries data");

  // Only a released run can leave the chunk unused.
  a_unused_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43] |-> out_tdata[41])
    else $error("chunk unused without a release");

endmodule

bind slab_run_allocator sra_checker u_sra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
